@@ rtl/rv64ie_pkg.sv @@
// Package with opcodes, payload types and pipeline stage type for the RV64IM execute unit.
package rv64ie_pkg;

   localparam logic [6:0] OPC_LUI     = 7'h37;
   localparam logic [6:0] OPC_AUIPC   = 7'h17;
   localparam logic [6:0] OPC_JAL     = 7'h6F;
   localparam logic [6:0] OPC_JALR    = 7'h67;
   localparam logic [6:0] OPC_BRANCH  = 7'h63;
   localparam logic [6:0] OPC_OPIMM   = 7'h13;
   localparam logic [6:0] OPC_OP      = 7'h33;
   localparam logic [6:0] OPC_OPIMM32 = 7'h1B;
   localparam logic [6:0] OPC_OP32    = 7'h3B;

   localparam logic [6:0] F7_ALT       = 7'h20;
   localparam logic [6:0] F7_MULDIV    = 7'h01;
   localparam logic [5:0] SHIFT_ARITH6 = 6'h10;

   // One radix-2 divider step per stage, plus decode and finalize stages.
   localparam int DIV_STEPS  = 64;
   localparam int NUM_STAGES = DIV_STEPS + 2;

   typedef enum logic [1:0] {
      K_ALU,
      K_MUL,
      K_DIV
   } kind_type;

   typedef struct packed {
      logic [31:0] instr;
      logic [63:0] pc;
      logic [63:0] rs1_value;
      logic [63:0] rs2_value;
   } req_type;

   typedef struct packed {
      logic        rd_write;
      logic [4:0]  rd_index;
      logic [63:0] rd_value;
      logic [63:0] next_pc;
      logic        illegal;
   } rsp_type;

   typedef struct packed {
      logic        valid;
      kind_type    kind;
      logic [2:0]  f3;
      logic        w;
      logic        div_neg;
      logic        div_zero;
      logic        rd_write;
      logic [4:0]  rd_index;
      logic        illegal;
      logic [63:0] next_pc;
      logic [63:0] value;
      logic [63:0] opa;
      logic [63:0] opb;
      logic [63:0] rem;
      logic [63:0] quo;
      logic [63:0] pp0;
      logic [63:0] pp1;
      logic [63:0] pp2;
      logic [63:0] pp3;
   } stg_type;

   function automatic logic [63:0] sx32(input logic [31:0] v);
      return {{32{v[31]}}, v};
   endfunction

endpackage

@@ rtl/rv64im_integer_execute_unit.sv @@
// RV64IM execute unit: decode and ALU stage, pipelined multiplier and divider, output stage.
// Every instruction passes through all pipeline stages from req acceptance to rsp_valid, whatever its kind.
// Throughput: one item per cycle while rsp_ready does not stall; the 64 radix-2 divider stages set the depth.
// A stall on rsp_ready holds the whole pipeline in place; req_ready follows it.
// Reset (synchronous, active high) empties the pipeline; no other state exists.
module rv64im_integer_execute_unit
   import rv64ie_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   stg_type st_ff [NUM_STAGES];
   stg_type st_in [NUM_STAGES];
   stg_type dec;
   logic    adv;

   assign adv       = !st_ff[NUM_STAGES-1].valid || rsp_ready;
   assign req_ready = adv;

   // Decode stage with combinational ALU.
   always_comb begin
      logic [31:0] ins;
      logic [63:0] a, b, pc, npc, v, imm_i, imm_u, imm_b, imm_j, xa, xb, msk;
      logic [6:0]  op, f7;
      logic [4:0]  rd;
      logic [2:0]  f3;
      logic [5:0]  sh6;
      logic [4:0]  sh5;
      logic        wr, ill, take, sgn, na, nb;
      ins   = req_data.instr;
      pc    = req_data.pc;
      a     = req_data.rs1_value;
      b     = req_data.rs2_value;
      op    = ins[6:0];
      rd    = ins[11:7];
      f3    = ins[14:12];
      f7    = ins[31:25];
      sh6   = ins[25:20];
      sh5   = ins[24:20];
      imm_i = {{52{ins[31]}}, ins[31:20]};
      imm_u = sx32({ins[31:12], 12'h000});
      imm_b = {{51{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
      imm_j = {{43{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
      npc   = pc + 64'd4;
      v     = '0;
      wr    = 1'b1;
      ill   = 1'b0;
      take  = 1'b0;
      dec   = '0;
      dec.kind = K_ALU;
      dec.f3   = f3;
      dec.opa  = a;
      dec.opb  = b;

      case (op)
         OPC_LUI:   v = imm_u;
         OPC_AUIPC: v = pc + imm_u;
         OPC_JAL: begin
            v   = pc + 64'd4;
            npc = pc + imm_j;
         end
         OPC_JALR: begin
            if (f3 != 3'd0) begin
               ill = 1'b1;
            end else begin
               v   = pc + 64'd4;
               npc = (a + imm_i) & ~64'd1;
            end
         end
         OPC_BRANCH: begin
            wr = 1'b0;
            case (f3)
               3'd0:    take = (a == b);
               3'd1:    take = (a != b);
               3'd4:    take = ($signed(a) < $signed(b));
               3'd5:    take = !($signed(a) < $signed(b));
               3'd6:    take = (a < b);
               3'd7:    take = (a >= b);
               default: ill = 1'b1;
            endcase
            if (!ill && take) npc = pc + imm_b;
         end
         OPC_OPIMM: begin
            case (f3)
               3'd0: v = a + imm_i;
               3'd2: v = {63'd0, $signed(a) < $signed(imm_i)};
               3'd3: v = {63'd0, a < imm_i};
               3'd4: v = a ^ imm_i;
               3'd6: v = a | imm_i;
               3'd7: v = a & imm_i;
               3'd1: begin
                  if (ins[31:26] != 6'd0) ill = 1'b1;
                  else v = a << sh6;
               end
               default: begin
                  if (ins[31:26] == 6'd0) v = a >> sh6;
                  else if (ins[31:26] == SHIFT_ARITH6) v = $unsigned($signed(a) >>> sh6);
                  else ill = 1'b1;
               end
            endcase
         end
         OPC_OP: begin
            if (f7 == F7_MULDIV) begin
               if (f3[2]) dec.kind = K_DIV;
               else dec.kind = K_MUL;
            end else if (f7 == 7'd0 || (f7 == F7_ALT && (f3 == 3'd0 || f3 == 3'd5))) begin
               case (f3)
                  3'd0: v = (f7 == F7_ALT) ? a - b : a + b;
                  3'd1: v = a << b[5:0];
                  3'd2: v = {63'd0, $signed(a) < $signed(b)};
                  3'd3: v = {63'd0, a < b};
                  3'd4: v = a ^ b;
                  3'd5: v = (f7 == F7_ALT) ? $unsigned($signed(a) >>> b[5:0]) : a >> b[5:0];
                  3'd6: v = a | b;
                  default: v = a & b;
               endcase
            end else begin
               ill = 1'b1;
            end
         end
         OPC_OPIMM32: begin
            if (f3 == 3'd0) v = sx32(a[31:0] + imm_i[31:0]);
            else if (f3 == 3'd1 && f7 == 7'd0) v = sx32(a[31:0] << sh5);
            else if (f3 == 3'd5 && f7 == 7'd0) v = sx32(a[31:0] >> sh5);
            else if (f3 == 3'd5 && f7 == F7_ALT)
               v = sx32($unsigned($signed(a[31:0]) >>> sh5));
            else ill = 1'b1;
         end
         OPC_OP32: begin
            if (f7 == F7_MULDIV) begin
               dec.w = 1'b1;
               if (f3[2]) dec.kind = K_DIV;
               else if (f3 == 3'd0) dec.kind = K_MUL;
               else ill = 1'b1;
            end else if (f7 == 7'd0 && f3 == 3'd0) v = sx32(a[31:0] + b[31:0]);
            else if (f7 == F7_ALT && f3 == 3'd0) v = sx32(a[31:0] - b[31:0]);
            else if (f7 == 7'd0 && f3 == 3'd1) v = sx32(a[31:0] << b[4:0]);
            else if (f7 == 7'd0 && f3 == 3'd5) v = sx32(a[31:0] >> b[4:0]);
            else if (f7 == F7_ALT && f3 == 3'd5)
               v = sx32($unsigned($signed(a[31:0]) >>> b[4:0]));
            else ill = 1'b1;
         end
         default: ill = 1'b1;
      endcase

      if (ill) begin
         wr       = 1'b0;
         npc      = pc + 64'd4;
         dec.kind = K_ALU;
      end

      // Divider operands become magnitudes; the sign is applied at the end.
      sgn = !f3[0];
      msk = dec.w ? 64'h0000_0000_FFFF_FFFF : '1;
      xa  = a & msk;
      xb  = b & msk;
      na  = sgn && (dec.w ? a[31] : a[63]);
      nb  = sgn && (dec.w ? b[31] : b[63]);
      if (dec.kind == K_DIV) begin
         v            = a;
         dec.opa      = na ? ((64'd0 - xa) & msk) : xa;
         dec.opb      = nb ? ((64'd0 - xb) & msk) : xb;
         dec.quo      = dec.opa;
         dec.div_neg  = f3[1] ? na : (na ^ nb);
         dec.div_zero = (xb == 64'd0);
      end

      dec.valid    = req_valid;
      dec.illegal  = ill;
      dec.next_pc  = npc;
      dec.value    = v;
      dec.rd_write = wr && (rd != 5'd0);
      dec.rd_index = dec.rd_write ? rd : 5'd0;
   end

   // ---------------- per-stage work ----------------
   function automatic stg_type div_step(input stg_type s);
      logic [64:0] t;
      logic        qb;
      t  = {s.rem, s.quo[63]};
      qb = (t >= {1'b0, s.opb});
      if (qb) t = t - {1'b0, s.opb};
      s.rem = t[63:0];
      s.quo = {s.quo[62:0], qb};
      return s;
   endfunction

   function automatic stg_type div_fin(input stg_type s);
      logic [63:0] r;
      r = s.f3[1] ? s.rem : s.quo;
      if (s.div_neg) r = 64'd0 - r;
      if (s.w) r = sx32(r[31:0]);
      if (s.div_zero) begin
         if (s.f3[1]) r = s.w ? sx32(s.value[31:0]) : s.value;
         else r = '1;
      end
      s.value = r;
      return s;
   endfunction

   function automatic stg_type mul_pp(input stg_type s);
      s.pp0 = s.opa[31:0]  * s.opb[31:0];
      s.pp1 = s.opa[31:0]  * s.opb[63:32];
      s.pp2 = s.opa[63:32] * s.opb[31:0];
      s.pp3 = s.opa[63:32] * s.opb[63:32];
      return s;
   endfunction

   function automatic stg_type mul_sum(input stg_type s);
      logic [127:0] p;
      p = {s.pp3, 64'd0} + {32'd0, s.pp1, 32'd0} + {32'd0, s.pp2, 32'd0} + {64'd0, s.pp0};
      s.rem = p[127:64];
      s.quo = p[63:0];
      return s;
   endfunction

   function automatic stg_type mul_fin(input stg_type s);
      logic [63:0] ca, cb;
      // Signed high halves come from the unsigned one by subtracting the cross terms.
      ca = s.opa[63] ? s.opb : 64'd0;
      cb = s.opb[63] ? s.opa : 64'd0;
      case (s.f3[1:0])
         2'd0:    s.value = s.w ? sx32(s.quo[31:0]) : s.quo;
         2'd1:    s.value = s.rem - ca - cb;
         2'd2:    s.value = s.rem - ca;
         default: s.value = s.rem;
      endcase
      return s;
   endfunction

   always_comb begin
      stg_type t;
      st_in[0] = dec;
      for (int k = 1; k < NUM_STAGES; k++) begin
         t = st_ff[k-1];
         if (t.kind == K_DIV) begin
            if (k - 1 < DIV_STEPS) t = div_step(t);
            else t = div_fin(t);
         end else if (t.kind == K_MUL) begin
            if (k == 1) t = mul_pp(t);
            else if (k == 2) t = mul_sum(t);
            else if (k == 3) t = mul_fin(t);
         end
         st_in[k] = t;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_STAGES; k++) st_ff[k].valid <= 1'b0;
      end else if (adv) begin
         for (int k = 0; k < NUM_STAGES; k++) st_ff[k] <= st_in[k];
      end
   end

   assign rsp_valid         = st_ff[NUM_STAGES-1].valid;
   assign rsp_data.rd_write = st_ff[NUM_STAGES-1].rd_write;
   assign rsp_data.rd_index = st_ff[NUM_STAGES-1].rd_index;
   assign rsp_data.rd_value = st_ff[NUM_STAGES-1].rd_write ? st_ff[NUM_STAGES-1].value : 64'd0;
   assign rsp_data.next_pc  = st_ff[NUM_STAGES-1].next_pc;
   assign rsp_data.illegal  = st_ff[NUM_STAGES-1].illegal;

endmodule

@@ rtl/rv64ie_checker.sv @@
// Port-level checker for the RV64IM execute unit, bound to the top level.
module rv64ie_checker
   import rv64ie_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp item changed while stalled");

   a_no_x0: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.rd_write && rsp_data.rd_index == 5'd0))
      else $error("write to x0 reported");

   a_illegal_nowr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.illegal |-> !rsp_data.rd_write && rsp_data.rd_value == 64'd0)
      else $error("illegal item writes a register");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid after reset");

   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("item accepted while the pipeline is stalled");

endmodule

bind rv64im_integer_execute_unit rv64ie_checker u_rv64ie_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
